// ===== rtl/core/bfst_pkg.sv =====
// Package for the butterfly segment-to-tile map: widths, register indexes,
// piece type codes and the per-axis layout record.
// No dependencies.
`default_nettype none

package bfst_pkg;

  localparam int ORDER_BITS_DEF = 16;
  localparam int TILE_BITS_DEF  = 10;

  localparam int COORD_W    = 16;
  localparam int TILE_IDX_W = 16;
  localparam int OFFSET_W   = 20;
  localparam int PIECE_W    = 6;
  localparam int TYPE_W     = 3;
  localparam int PIECE_MULT = 6;

  localparam int ORDER_W   = 16;
  localparam int TSIZE_W   = 11;
  localparam int LEVEL_W   = 4;
  localparam int BLK_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // position width covers every legal ORDER_BITS / TILE_BITS
  localparam int POS_W  = 34;
  localparam int TW_MAX = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COL    = 3'd4;

  localparam logic [ORDER_W-1:0] RST_MATRIX_ORDER = 16'd1024;
  localparam logic [TSIZE_W-1:0] RST_TILE_SIZE    = 11'd64;
  localparam logic [LEVEL_W-1:0] RST_LEVEL        = 4'd0;
  localparam logic [BLK_W-1:0]   RST_BLOCK       = 8'd0;

  localparam logic [TYPE_W-1:0] PT_FIRST    = 3'd0;
  localparam logic [TYPE_W-1:0] PT_FIRST_B  = 3'd1;
  localparam logic [TYPE_W-1:0] PT_CENTER   = 3'd2;
  localparam logic [TYPE_W-1:0] PT_CENTER_B = 3'd3;
  localparam logic [TYPE_W-1:0] PT_LAST     = 3'd4;
  localparam logic [TYPE_W-1:0] PT_LAST_B   = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0]  sp;
    logic [POS_W-1:0]  cbase;
    logic [POS_W-1:0]  ebase;
    logic [POS_W-1:0]  span;
    logic [POS_W-1:0]  half;
    logic [POS_W-1:0]  cend;
    logic [1:0]        e1cnt;
    logic              cc2;
    logic [TW_MAX-1:0] e1a;
    logic [TW_MAX-1:0] c1;
    logic [TW_MAX-1:0] e2a;
  } axis_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfst_in_if.sv =====
// Input channel: one segment coordinate pair per beat.
// Depends on bfst_pkg.
`default_nettype none

interface bfst_in_if import bfst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] seg_row;
  logic [COORD_W-1:0] seg_col;

  modport source (output valid, seg_row, seg_col, input ready);
  modport sink   (input valid, seg_row, seg_col, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfst_out_if.sv =====
// Output channel: tile position, offset and piece type per beat.
// Depends on bfst_pkg.
`default_nettype none

interface bfst_out_if import bfst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TILE_IDX_W-1:0] tile_row;
  logic [TILE_IDX_W-1:0] tile_col;
  logic [OFFSET_W-1:0]   tile_offset;
  logic [PIECE_W-1:0]    piece_type;
  logic                  coord_valid;

  modport source (output valid, tile_row, tile_col, tile_offset, piece_type, coord_valid,
                  input ready);
  modport sink   (input valid, tile_row, tile_col, tile_offset, piece_type, coord_valid,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfst_layout.sv =====
// Configuration registers and the sequencer that derives the row and column
// segment layout, with a shared bit-serial divider. Depends on bfst_pkg.
`default_nettype none

module bfst_layout import bfst_pkg::*; #(
  parameter int ORDER_BITS = ORDER_BITS_DEF,
  parameter int TILE_BITS  = TILE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 busy,
  output logic [TILE_BITS:0]   tsz,
  output axis_t                lay_row,
  output axis_t                lay_col
);

  localparam int NB    = (ORDER_BITS < ORDER_W) ? ORDER_BITS : ORDER_W;
  localparam int TW    = TILE_BITS + 1;
  localparam int AW    = ((NB + 8 > COORD_W + TW) ? NB + 8 : COORD_W + TW) + 2;
  localparam int CNT_W = $clog2(AW);
  localparam int CMP_W = (TSIZE_W > TW) ? TSIZE_W : TW;
  localparam int TMAX  = 1 << TILE_BITS;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_POS  = 9'b000000010,
    ST_MP   = 9'b000000100,
    ST_DIVA = 9'b000001000,
    ST_DIVC = 9'b000010000,
    ST_MID  = 9'b000100000,
    ST_EDGE = 9'b001000000,
    ST_DIVS = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state;
  logic   ax;

  logic [ORDER_W-1:0] r_order;
  logic [TSIZE_W-1:0] r_tile;
  logic [LEVEL_W-1:0] r_level;
  logic [BLK_W-1:0]   r_brow;
  logic [BLK_W-1:0]   r_bcol;

  logic [POS_W-1:0] sp, spe, mp, cs, cseg;
  logic [TW-1:0]    a, c, b, e, e1a, e1b, e2a, e2b, c1;
  logic [1:0]       e1cnt, e2cnt, ccnt;

  logic [AW-1:0]    dnum, dquo;
  logic [TW-1:0]    drem;
  logic [CNT_W-1:0] dcnt;

  logic [CMP_W-1:0] tile_ext;
  logic [TW-1:0]    tclamp;
  logic [BLK_W-1:0] blk;
  logic [NB-1:0]    nval;
  logic [NB+7:0]    prod;
  logic [NB+8:0]    prod_end;
  logic [TW:0]      dsh;
  logic             dge;
  logic [TW-1:0]    drem_next;
  logic [AW-1:0]    dquo_next;
  logic             wr_ok;

  logic [TW-1:0]    mid_b, mid_d, mid_e;
  logic [TW:0]      mid_wrap;
  logic [POS_W-1:0] tpos, ed_ce;
  logic [TW-1:0]    ed_f;
  logic             ed_mp_gt, ed_short;
  logic [1:0]       ed_e1cnt, ed_e2cnt, ed_ccnt;
  logic [TW-1:0]    ed_e1a, ed_e1b, ed_e2a, ed_e2b, ed_c1;
  axis_t            done_ax;

  assign busy  = (state != ST_IDLE);
  assign wr_ok = cfg_we && (cfg_index <= REG_BLOCK_COL);

  always_comb begin
    tile_ext = CMP_W'(r_tile);
    if (r_tile == '0) begin
      tclamp = TW'(1);
    end else if (tile_ext > CMP_W'(TMAX)) begin
      tclamp = TW'(TMAX);
    end else begin
      tclamp = TW'(tile_ext);
    end
  end

  assign blk      = ax ? r_bcol : r_brow;
  assign nval     = r_order[NB-1:0];
  assign prod     = (NB+8)'(blk) * (NB+8)'(nval);
  assign prod_end = (NB+9)'(prod) + (NB+9)'(nval);

  assign dsh       = {drem, dnum[AW-1]};
  assign dge       = dsh >= {1'b0, tsz};
  assign drem_next = dge ? TW'(dsh - {1'b0, tsz}) : dsh[TW-1:0];
  assign dquo_next = {dquo[AW-2:0], dge};

  always_comb begin
    mid_b    = tsz - a;
    mid_d    = tsz - c;
    mid_wrap = {1'b0, tsz} + {1'b0, mid_d} - {1'b0, mid_b};
    mid_e    = (mid_d > mid_b) ? (mid_d - mid_b) : mid_wrap[TW-1:0];
  end

  always_comb begin
    tpos     = POS_W'(tsz);
    ed_f     = tsz - e;
    ed_mp_gt = mp > cs + tpos;
    ed_ce    = ed_mp_gt ? mp - POS_W'(c) : mp;
    ed_short = ed_ce < cs + tpos;
    ed_e1cnt = 2'd0;
    ed_e1a   = '0;
    ed_e1b   = '0;
    if (b != tsz) begin
      if (ed_f < b) begin
        ed_e1cnt = 2'd2;
        ed_e1a   = b - ed_f;
        ed_e1b   = ed_f;
      end else begin
        ed_e1cnt = 2'd1;
        ed_e1a   = b;
      end
    end
    ed_e2cnt = 2'd0;
    ed_e2a   = '0;
    ed_e2b   = '0;
    if (c != '0 && ed_mp_gt) begin
      if (e < c) begin
        ed_e2cnt = 2'd2;
        ed_e2a   = e;
        ed_e2b   = c - e;
      end else begin
        ed_e2cnt = 2'd1;
        ed_e2a   = c;
      end
    end
    ed_ccnt = 2'd0;
    ed_c1   = '0;
    if (ed_f != '0 && mp > cs + POS_W'(e)) begin
      ed_ccnt = 2'd2;
      ed_c1   = e;
    end else if (cs + POS_W'(e) <= mp) begin
      ed_ccnt = 2'd1;
      ed_c1   = e;
    end
  end

  always_comb begin
    done_ax.sp    = sp;
    done_ax.cbase = sp + POS_W'(e1a) + POS_W'(e1b);
    done_ax.ebase = mp - POS_W'(e2a) - POS_W'(e2b);
    done_ax.span  = mp - sp;
    done_ax.half  = POS_W'(e1cnt) + cseg + POS_W'(e2cnt);
    done_ax.cend  = POS_W'(e1cnt) + cseg;
    done_ax.e1cnt = e1cnt;
    done_ax.cc2   = (ccnt == 2'd2);
    done_ax.e1a   = TW_MAX'(e1a);
    done_ax.c1    = TW_MAX'(c1);
    done_ax.e2a   = TW_MAX'(e2a);
  end

  always_ff @(posedge clk) begin
    tsz <= tclamp;
    if (rst) begin
      r_order <= RST_MATRIX_ORDER;
      r_tile  <= RST_TILE_SIZE;
      r_level <= RST_LEVEL;
      r_brow  <= RST_BLOCK;
      r_bcol  <= RST_BLOCK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATRIX_ORDER: r_order <= cfg_data[ORDER_W-1:0];
        REG_TILE_SIZE:    r_tile  <= cfg_data[TSIZE_W-1:0];
        REG_LEVEL:        r_level <= cfg_data[LEVEL_W-1:0];
        REG_BLOCK_ROW:    r_brow  <= cfg_data[BLK_W-1:0];
        REG_BLOCK_COL:    r_bcol  <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_POS;
      ax    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: ;
        ST_POS: begin
          sp    <= POS_W'(prod >> r_level);
          spe   <= POS_W'(prod_end >> r_level);
          state <= ST_MP;
        end
        ST_MP: begin
          mp    <= (sp + spe) >> 1;
          dnum  <= sp[AW-1:0];
          drem  <= '0;
          dquo  <= '0;
          dcnt  <= CNT_W'(AW - 1);
          state <= ST_DIVA;
        end
        ST_DIVA: begin
          dnum <= dnum << 1;
          drem <= drem_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            a     <= drem_next;
            dnum  <= mp[AW-1:0];
            drem  <= '0;
            dcnt  <= CNT_W'(AW - 1);
            state <= ST_DIVC;
          end
        end
        ST_DIVC: begin
          dnum <= dnum << 1;
          drem <= drem_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            c     <= drem_next;
            state <= ST_MID;
          end
        end
        ST_MID: begin
          b     <= mid_b;
          e     <= mid_e;
          cs    <= sp + ((mid_b != tsz) ? POS_W'(mid_b) : '0);
          state <= ST_EDGE;
        end
        ST_EDGE: begin
          e1cnt <= ed_e1cnt;
          e1a   <= ed_e1a;
          e1b   <= ed_e1b;
          e2cnt <= ed_e2cnt;
          e2a   <= ed_e2a;
          e2b   <= ed_e2b;
          ccnt  <= ed_ccnt;
          c1    <= ed_c1;
          drem  <= '0;
          dquo  <= '0;
          dcnt  <= CNT_W'(AW - 1);
          if (ed_ccnt == 2'd2) begin
            dnum  <= AW'((ed_ce - cs) << 1);
            state <= ST_DIVS;
          end else if (ed_ccnt == 2'd1 && !ed_short) begin
            dnum  <= AW'(ed_ce - cs);
            state <= ST_DIVS;
          end else begin
            cseg  <= (ed_ccnt == 2'd1) ? POS_W'(1) : '0;
            state <= ST_DONE;
          end
        end
        ST_DIVS: begin
          dnum <= dnum << 1;
          drem <= drem_next;
          dquo <= dquo_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            cseg  <= POS_W'(dquo_next);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ax) begin
            lay_col <= done_ax;
            state   <= ST_IDLE;
          end else begin
            lay_row <= done_ax;
            state   <= ST_POS;
          end
          ax <= ~ax;
        end
        default: state <= ST_IDLE;
      endcase
      if (wr_ok) begin
        state <= ST_POS;
        ax    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/butterfly_segment_to_tile_map.sv =====
// One beat per cycle, but held while an output beat waits for map_out.ready
// or the layout sequencer is busy; AW, the divider depth, is 29 at default parameters.
// The tile divide is a pipelined restoring divider, one quotient bit per stage.
// After reset and after each write to registers 0 to 4 the layout sequencer runs
// with seg_in.ready low.
// Depends on bfst_pkg, bfst_in_if, bfst_out_if, bfst_layout.
`default_nettype none

module butterfly_segment_to_tile_map import bfst_pkg::*; #(
  parameter int ORDER_BITS = ORDER_BITS_DEF,
  parameter int TILE_BITS  = TILE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bfst_in_if.sink              seg_in,
  bfst_out_if.source           map_out
);

  localparam int NB = (ORDER_BITS < ORDER_W) ? ORDER_BITS : ORDER_W;
  localparam int TW = TILE_BITS + 1;
  localparam int AW = ((NB + 8 > COORD_W + TW) ? NB + 8 : COORD_W + TW) + 2;
  localparam int QW = COORD_W + TW;
  localparam int OW = (2 * TW + 1 > OFFSET_W) ? 2 * TW + 1 : OFFSET_W;

  typedef struct packed {
    logic [POS_W-1:0]   base;
    logic [TW_MAX-1:0]  add;
    logic [COORD_W-1:0] q;
    logic               isc;
    logic [TYPE_W-1:0]  typ;
  } cls_t;

  logic          busy;
  logic [TW-1:0] tsz;
  axis_t         lay_row, lay_col;

  bfst_layout #(.ORDER_BITS(ORDER_BITS), .TILE_BITS(TILE_BITS)) u_layout (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .busy(busy), .tsz(tsz), .lay_row(lay_row), .lay_col(lay_col)
  );

  function automatic cls_t classify(input axis_t x, input logic [COORD_W-1:0] k);
    cls_t               o;
    logic [POS_W-1:0]   kx;
    logic [COORD_W-1:0] r;
    logic               odd;
    kx  = POS_W'(k);
    r   = k - COORD_W'(x.e1cnt);
    odd = x.cc2 & r[0];
    o   = '0;
    if (kx < POS_W'(x.e1cnt)) begin
      o.base = x.sp;
      o.add  = (k == COORD_W'(1)) ? x.e1a : '0;
      o.typ  = (k == COORD_W'(1)) ? PT_FIRST_B : PT_FIRST;
    end else if (kx < x.cend) begin
      o.base = x.cbase;
      o.q    = x.cc2 ? (r >> 1) : r;
      o.isc  = 1'b1;
      o.add  = odd ? x.c1 : '0;
      o.typ  = odd ? PT_CENTER_B : PT_CENTER;
    end else begin
      o.base = x.ebase;
      o.add  = (kx != x.cend) ? x.e2a : '0;
      o.typ  = (kx != x.cend) ? PT_LAST_B : PT_LAST;
    end
    return o;
  endfunction

  function automatic logic [TW:0] div_step(input logic [TW-1:0] rem, input logic bin,
                                           input logic [TW-1:0] d);
    logic [TW:0] sh;
    sh = {rem, bin};
    if (sh >= {1'b0, d}) begin
      div_step = {1'b1, TW'(sh - {1'b0, d})};
    end else begin
      div_step = {1'b0, sh[TW-1:0]};
    end
  endfunction

  logic en, in_fire;
  logic out_v;

  assign en           = ~out_v | map_out.ready;
  assign seg_in.ready = en & ~busy;
  assign in_fire      = seg_in.valid & seg_in.ready;

  // stage 1: capture
  logic               v1;
  logic [COORD_W-1:0] m1, n1;
  // stage 2: fold into half
  logic               v2, ok2, sec2r, sec2c;
  logic [COORD_W-1:0] k2r, k2c;
  // stage 3: piece classification
  logic               v3, ok3, sec3r, sec3c;
  cls_t               c3r, c3c;
  // stage 4: center product and base sum
  logic               v4, ok4;
  logic [QW-1:0]      p4r, p4c;
  logic [POS_W-1:0]   b4r, b4c;
  logic [PIECE_W-1:0] pc4;

  logic               sec_r, sec_c;
  logic [POS_W-1:0]   mx, nx;

  assign mx    = POS_W'(m1);
  assign nx    = POS_W'(n1);
  assign sec_r = mx >= lay_row.half;
  assign sec_c = nx >= lay_col.half;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= seg_in.seg_row;
      n1 <= seg_in.seg_col;

      ok2   <= (mx < (lay_row.half << 1)) && (nx < (lay_col.half << 1));
      sec2r <= sec_r;
      sec2c <= sec_c;
      k2r   <= sec_r ? COORD_W'(mx - lay_row.half) : m1;
      k2c   <= sec_c ? COORD_W'(nx - lay_col.half) : n1;

      ok3   <= ok2;
      sec3r <= sec2r;
      sec3c <= sec2c;
      c3r   <= classify(lay_row, k2r);
      c3c   <= classify(lay_col, k2c);

      ok4 <= ok3;
      p4r <= c3r.isc ? QW'(c3r.q) * QW'(tsz) : '0;
      p4c <= c3c.isc ? QW'(c3c.q) * QW'(tsz) : '0;
      b4r <= c3r.base + POS_W'(c3r.add) + (sec3r ? lay_row.span : '0);
      b4c <= c3c.base + POS_W'(c3c.add) + (sec3c ? lay_col.span : '0);
      pc4 <= PIECE_W'(c3r.typ) * PIECE_W'(PIECE_MULT) + PIECE_W'(c3c.typ);
    end
  end

  // divider pipeline; index 0 holds the absolute start positions
  logic [AW-1:0]      dnr [0:AW];
  logic [AW-1:0]      dnc [0:AW];
  logic [AW-1:0]      dqr [0:AW];
  logic [AW-1:0]      dqc [0:AW];
  logic [TW-1:0]      drr [0:AW];
  logic [TW-1:0]      drc [0:AW];
  logic [PIECE_W-1:0] dpc [0:AW];
  logic               dok [0:AW];
  logic               dv  [0:AW];

  logic [POS_W-1:0] abs_r, abs_c;
  assign abs_r = b4r + POS_W'(p4r);
  assign abs_c = b4c + POS_W'(p4c);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnr[0] <= abs_r[AW-1:0];
      dnc[0] <= abs_c[AW-1:0];
      dqr[0] <= '0;
      dqc[0] <= '0;
      drr[0] <= '0;
      drc[0] <= '0;
      dpc[0] <= pc4;
      dok[0] <= ok4;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < AW; gi++) begin : g_div
      logic [TW:0] sr, sc;
      assign sr = div_step(drr[gi], dnr[gi][AW-1], tsz);
      assign sc = div_step(drc[gi], dnc[gi][AW-1], tsz);

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[gi+1] <= 1'b0;
        end else if (en) begin
          dv[gi+1] <= dv[gi];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dnr[gi+1] <= dnr[gi] << 1;
          dnc[gi+1] <= dnc[gi] << 1;
          drr[gi+1] <= sr[TW-1:0];
          drc[gi+1] <= sc[TW-1:0];
          dqr[gi+1] <= {dqr[gi][AW-2:0], sr[TW]};
          dqc[gi+1] <= {dqc[gi][AW-2:0], sc[TW]};
          dpc[gi+1] <= dpc[gi];
          dok[gi+1] <= dok[gi];
        end
      end
    end
  endgenerate

  // offset product, then output register
  logic                  vm, okm;
  logic [2*TW-1:0]       offp;
  logic [TW-1:0]         remm;
  logic [TILE_IDX_W-1:0] qrm, qcm;
  logic [PIECE_W-1:0]    pcm;
  logic [OW-1:0]         offs;

  assign offs = OW'(offp) + OW'(remm);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      vm    <= dv[AW];
      out_v <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offp <= (2*TW)'(drc[AW]) * (2*TW)'(tsz);
      remm <= drr[AW];
      qrm  <= dqr[AW][TILE_IDX_W-1:0];
      qcm  <= dqc[AW][TILE_IDX_W-1:0];
      pcm  <= dpc[AW];
      okm  <= dok[AW];

      map_out.tile_row    <= okm ? qrm : '0;
      map_out.tile_col    <= okm ? qcm : '0;
      map_out.tile_offset <= okm ? offs[OFFSET_W-1:0] : '0;
      map_out.piece_type  <= okm ? pcm : '0;
      map_out.coord_valid <= okm;
    end
  end

  assign map_out.valid = out_v;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for butterfly_segment_to_tile_map: random and directed coordinate beats
// across several layout configurations, checked against an in-bench mapping predictor.
// Depends on bfst_pkg, bfst_in_if, bfst_out_if and the block itself.
`default_nettype none

module tb import bfst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint sp, mp;
    longint e1cnt, e1a, e1b;
    longint ccnt, c1, cseg;
    longint e2cnt, e2a, e2b;
    longint tot;
  } seg_axis_t;

  typedef struct {
    logic [TILE_IDX_W-1:0] tile_row;
    logic [TILE_IDX_W-1:0] tile_col;
    logic [OFFSET_W-1:0]   tile_offset;
    logic [PIECE_W-1:0]    piece_type;
    logic                  coord_valid;
  } tile_map_t;

  typedef struct {
    logic [COORD_W-1:0] seg_row;
    logic [COORD_W-1:0] seg_col;
  } seg_coord_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bfst_in_if  seg_in ();
  bfst_out_if map_out ();

  butterfly_segment_to_tile_map u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .seg_in(seg_in), .map_out(map_out)
  );

  // configuration shadow and derived layout
  longint order_n, tile_t, level_l, blk_r, blk_c, tile_eff;
  seg_axis_t row_ax, col_ax;

  seg_coord_t coord_q[$];
  tile_map_t  tile_map_q[$];
  int errors;
  int cycles;
  bit no_idle;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic seg_axis_t derive_axis(longint blk, longint n, longint bc, longint t);
    seg_axis_t x;
    longint ep, a, b, c, d, e, f, cs, ce;
    x.sp = blk * n / bc;
    ep = (blk + 1) * n / bc - 1;
    x.mp = (x.sp + ep + 1) / 2;
    a = x.sp % t; b = t - a;
    c = x.mp % t; d = t - c;
    e = (d > b) ? d - b : t + (d - b);
    f = t - e;
    cs = x.sp;
    if (b != t) cs += b;
    ce = x.mp;
    if (c != t && x.mp > cs + t) ce -= c;
    x.e1cnt = 0; x.e1a = 0; x.e1b = 0;
    if (b < f + e) begin
      if (f < b) begin x.e1cnt = 2; x.e1a = b - f; x.e1b = f; end
      else begin x.e1cnt = 1; x.e1a = b; x.e1b = 0; end
    end
    x.e2cnt = 0; x.e2a = 0; x.e2b = 0;
    if (c < e + f && c != 0 && x.mp - (cs + t) > 0) begin
      if (e < c) begin x.e2cnt = 2; x.e2a = e; x.e2b = c - e; end
      else begin x.e2cnt = 1; x.e2a = c; x.e2b = 0; end
    end
    x.ccnt = 0; x.c1 = 0;
    if (f > 0 && x.mp - (cs + e) > 0) begin x.ccnt = 2; x.c1 = e; end
    else if (e <= x.mp - cs) begin x.ccnt = 1; x.c1 = e; end
    if (x.ccnt == 1 && ce - cs < t) x.cseg = 1;
    else x.cseg = x.ccnt * (ce - cs) / t;
    x.tot = 2 * (x.e1cnt + x.cseg + x.e2cnt);
    return x;
  endfunction

  function automatic void relayout();
    longint t;
    t = tile_t;
    if (t < 1) t = 1;
    if (t > (longint'(1) << TILE_BITS_DEF)) t = longint'(1) << TILE_BITS_DEF;
    tile_eff = t;
    row_ax = derive_axis(blk_r, order_n, longint'(1) << level_l, t);
    col_ax = derive_axis(blk_c, order_n, longint'(1) << level_l, t);
  endfunction

  function automatic void locate(seg_axis_t x, longint k, output longint pos,
                                 output logic [TYPE_W-1:0] kind);
    longint half, r, cc;
    bit second;
    half = x.tot / 2;
    second = 0;
    if (k >= half) begin k -= half; second = 1; end
    if (k < x.e1cnt) begin
      pos = x.sp;
      kind = PT_FIRST;
      if (k == 1) begin pos += x.e1a; kind = PT_FIRST_B; end
    end else if (k < x.e1cnt + x.cseg) begin
      cc = x.ccnt > 0 ? x.ccnt : 1;
      r = k - x.e1cnt;
      pos = x.sp + x.e1a + x.e1b + (r / cc) * tile_eff;
      kind = PT_CENTER;
      if (r % cc != 0) begin pos += x.c1; kind = PT_CENTER_B; end
    end else begin
      pos = x.mp - (x.e2a + x.e2b);
      kind = PT_LAST;
      if (k - (x.e1cnt + x.cseg) != 0) begin pos += x.e2a; kind = PT_LAST_B; end
    end
    if (second) pos += x.mp - x.sp;
  endfunction

  function automatic tile_map_t map_segment(seg_coord_t s);
    tile_map_t m;
    longint am, an;
    logic [TYPE_W-1:0] tm, tn;
    m = '{default: '0};
    if (longint'(s.seg_col) >= col_ax.tot || longint'(s.seg_row) >= row_ax.tot) return m;
    locate(row_ax, longint'(s.seg_row), am, tm);
    locate(col_ax, longint'(s.seg_col), an, tn);
    m.tile_row    = TILE_IDX_W'(am / tile_eff);
    m.tile_col    = TILE_IDX_W'(an / tile_eff);
    m.tile_offset = OFFSET_W'((an % tile_eff) * tile_eff + (am % tile_eff));
    m.piece_type  = PIECE_W'(tm * PIECE_MULT + tn);
    m.coord_valid = 1'b1;
    return m;
  endfunction

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(20, 4);
    return $urandom_range(100, 30);
  endfunction

  // sender
  int send_gap;
  always @(posedge clk) begin
    seg_coord_t nxt;
    if (rst) begin
      seg_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (seg_in.valid && seg_in.ready)
        tile_map_q.push_back(map_segment('{seg_in.seg_row, seg_in.seg_col}));
      if (seg_in.valid && !seg_in.ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        seg_in.valid <= 1'b0;
      end else if (coord_q.size() > 0) begin
        nxt = coord_q.pop_front();
        seg_in.valid   <= 1'b1;
        seg_in.seg_row <= nxt.seg_row;
        seg_in.seg_col <= nxt.seg_col;
        send_gap = gap_len();
      end else begin
        seg_in.valid <= 1'b0;
      end
    end
  end

  // receiver
  int recv_gap;
  always @(posedge clk) begin
    tile_map_t want;
    if (rst) begin
      map_out.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (map_out.valid && map_out.ready) begin
        if (tile_map_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat row=%0d col=%0d", $time, map_out.tile_row,
                   map_out.tile_col);
        end else begin
          want = tile_map_q.pop_front();
          if (map_out.tile_row !== want.tile_row) begin
            errors++;
            $display("%0t: tile_row exp %0d got %0d", $time, want.tile_row, map_out.tile_row);
          end
          if (map_out.tile_col !== want.tile_col) begin
            errors++;
            $display("%0t: tile_col exp %0d got %0d", $time, want.tile_col, map_out.tile_col);
          end
          if (map_out.tile_offset !== want.tile_offset) begin
            errors++;
            $display("%0t: tile_offset exp %0d got %0d", $time, want.tile_offset,
                     map_out.tile_offset);
          end
          if (map_out.piece_type !== want.piece_type) begin
            errors++;
            $display("%0t: piece_type exp %0d got %0d", $time, want.piece_type,
                     map_out.piece_type);
          end
          if (map_out.coord_valid !== want.coord_valid) begin
            errors++;
            $display("%0t: coord_valid exp %0d got %0d", $time, want.coord_valid,
                     map_out.coord_valid);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        map_out.ready <= 1'b0;
      end else begin
        map_out.ready <= 1'b1;
        recv_gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (coord_q.size() != 0 || tile_map_q.size() != 0 || seg_in.valid);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MATRIX_ORDER: order_n = val;
      REG_TILE_SIZE:    tile_t  = val & 16'h07FF;
      REG_LEVEL:        level_l = val & 16'h000F;
      REG_BLOCK_ROW:    blk_r   = val & 16'h00FF;
      REG_BLOCK_COL:    blk_c   = val & 16'h00FF;
      default: ;
    endcase
    relayout();
  endtask

  task automatic load_layout(int n, int t, int l, int br, int bc);
    write_reg(REG_MATRIX_ORDER, CFG_W'(n));
    write_reg(REG_TILE_SIZE, CFG_W'(t));
    write_reg(REG_LEVEL, CFG_W'(l));
    write_reg(REG_BLOCK_ROW, CFG_W'(br));
    write_reg(REG_BLOCK_COL, CFG_W'(bc));
    write_reg(CFG_IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(longint tot);
    int p;
    p = $urandom_range(99);
    if (p < 85 && tot > 0) return COORD_W'($urandom_range(int'(tot) - 1));
    if (p < 93) return COORD_W'(tot + $urandom_range(3));
    return COORD_W'($urandom);
  endfunction

  task automatic queue_coords(int count, bit directed);
    longint k;
    if (directed) begin
      coord_q.push_back('{16'd0, 16'd0});
      coord_q.push_back('{16'hFFFF, 16'hFFFF});
      coord_q.push_back('{16'hFFFF, 16'd0});
      coord_q.push_back('{COORD_W'(row_ax.tot), 16'd0});
      coord_q.push_back('{16'd0, COORD_W'(col_ax.tot)});
      for (k = 0; k < row_ax.tot && k < 8; k++)
        coord_q.push_back('{COORD_W'(k), COORD_W'(col_ax.tot > 0 ? k % col_ax.tot : 0)});
      for (k = 0; k < col_ax.tot && k < 8; k++)
        coord_q.push_back('{COORD_W'(row_ax.tot > 0 ? row_ax.tot - 1 : 0), COORD_W'(k)});
    end
    repeat (count) coord_q.push_back('{pick_coord(row_ax.tot), pick_coord(col_ax.tot)});
  endtask

  initial begin
    int lv;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    seg_in.valid = 1'b0;
    seg_in.seg_row = '0;
    seg_in.seg_col = '0;
    map_out.ready = 1'b0;
    errors = 0;
    cycles = 0;
    no_idle = 0;
    order_n = RST_MATRIX_ORDER;
    tile_t  = RST_TILE_SIZE;
    level_l = RST_LEVEL;
    blk_r   = RST_BLOCK;
    blk_c   = RST_BLOCK;
    relayout();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_coords(20, 1);
    wait_drained();
    load_layout(1000, 48, 2, 1, 3);
    queue_coords(20, 1);
    wait_drained();
    load_layout(1, 1, 0, 0, 0);
    queue_coords(5, 1);
    wait_drained();
    load_layout(0, 0, 0, 0, 0);
    queue_coords(5, 1);
    wait_drained();
    load_layout(65535, 2047, 8, 255, 0);
    queue_coords(15, 1);
    wait_drained();
    load_layout(65535, 1024, 15, 255, 255);
    queue_coords(10, 1);
    wait_drained();
    load_layout(777, 1, 3, 5, 2);
    no_idle = 1;
    queue_coords(20, 1);
    wait_drained();
    no_idle = 0;
    repeat (12) begin
      lv = $urandom_range(8);
      load_layout($urandom_range(65535, 1), $urandom_range(1024, 1), lv,
                  $urandom_range((1 << lv) - 1), $urandom_range((1 << lv) - 1));
      no_idle = ($urandom_range(3) == 0);
      queue_coords(15, 1);
      wait_drained();
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
